// ----- rtl/pfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pfp_pkg;

   localparam int UrgencyWidth = 3;
   localparam int AccumWidth   = 4;
   localparam int IndexWidth   = 1;
   localparam int CsrDataWidth = 3;

   localparam logic [IndexWidth-1:0] CSR_URGENCY_DEFAULT = 1'b0;
   localparam logic [IndexWidth-1:0] CSR_URGENCY_LIMIT   = 1'b1;

   localparam logic [UrgencyWidth-1:0] URGENCY_DEFAULT_RESET = 3'd3;
   localparam logic [UrgencyWidth-1:0] URGENCY_LIMIT_RESET   = 3'd7;

   typedef enum logic [8:0] {
      PH_START       = 9'b000000001,
      PH_AFTER_COMMA = 9'b000000010,
      PH_KEY         = 9'b000000100,
      PH_VALUE_FIRST = 9'b000001000,
      PH_BOOL_DIGIT  = 9'b000010000,
      PH_STRING      = 9'b000100000,
      PH_STRING_ESC  = 9'b001000000,
      PH_BARE        = 9'b010000000,
      PH_PARAMS      = 9'b100000000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_U     = 2'd1,
      KIND_I     = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   typedef struct packed {
      phase_type                phase;
      kind_type                 key_kind;
      logic                     value_negative;
      logic                     digits_seen;
      logic                     all_digits;
      logic [AccumWidth-1:0]    number_accum;
      logic                     member_is_bool;
      logic                     member_bool_value;
      logic                     error_seen;
      logic [UrgencyWidth-1:0]  urgency_held;
      logic                     incremental_held;
      logic                     urgency_found;
      logic                     incremental_found;
   } parse_state_type;

   typedef struct packed {
      logic [UrgencyWidth-1:0] urgency_default;
      logic [UrgencyWidth-1:0] urgency_limit;
   } pfp_cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       empty_value;
   } pfp_req_type;

   typedef struct packed {
      logic                    accepted;
      logic [UrgencyWidth-1:0] urgency;
      logic                    incremental;
      logic                    urgency_present;
      logic                    incremental_present;
   } pfp_rsp_type;

endpackage
`default_nettype wire

// ----- rtl/pfp_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pfp_step (
   input  pfp_pkg::parse_state_type state_cur,
   input  pfp_pkg::pfp_req_type     item,
   input  pfp_pkg::pfp_cfg_type     cfg,
   output pfp_pkg::parse_state_type state_next,
   output logic                     result_valid,
   output pfp_pkg::pfp_rsp_type     result
);

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TILDE  = 8'h7e;
   localparam logic [7:0] CH_QUEST  = 8'h3f;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_EQUAL  = 8'h3d;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_UNDER  = 8'h5f;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_I  = 8'h69;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_LOW_Z  = 8'h7a;
   localparam logic [7:0] AccumMax  = 8'd15;

   pfp_pkg::parse_state_type cleared;
   pfp_pkg::parse_state_type stepped;
   pfp_pkg::parse_state_type finished;
   logic [7:0] c;
   logic       visible;
   logic       digit;
   logic       key_first;
   logic       key_tail;
   logic [7:0] accum_sum;
   logic       ok;

   function automatic pfp_pkg::parse_state_type apply_member(
      input pfp_pkg::parse_state_type s,
      input logic [pfp_pkg::UrgencyWidth-1:0] limit
   );
      pfp_pkg::parse_state_type r;
      r = s;
      if (s.key_kind == pfp_pkg::KIND_U) begin
         if (s.digits_seen && s.all_digits
             && (s.number_accum <= {1'b0, limit})
             && (!s.value_negative || (s.number_accum == '0))) begin
            r.urgency_held  = s.number_accum[pfp_pkg::UrgencyWidth-1:0];
            r.urgency_found = 1'b1;
         end
      end else if (s.key_kind == pfp_pkg::KIND_I) begin
         if (s.member_is_bool) begin
            r.incremental_held  = s.member_bool_value;
            r.incremental_found = 1'b1;
         end
      end
      return r;
   endfunction

   assign c         = item.data_byte;
   assign visible   = (c >= CH_SPACE) && (c <= CH_TILDE);
   assign digit     = (c >= CH_ZERO) && (c <= CH_NINE);
   assign key_first = ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || (c == CH_STAR);
   assign key_tail  = key_first || digit || (c == CH_UNDER) || (c == CH_MINUS)
                      || (c == CH_DOT);
   assign accum_sum = 8'({4'b0, state_cur.number_accum} * 8'd10 + (c - CH_ZERO));

   always_comb begin
      cleared                   = '0;
      cleared.phase             = pfp_pkg::PH_START;
      cleared.key_kind          = pfp_pkg::KIND_NONE;
      cleared.all_digits        = 1'b1;
      cleared.member_is_bool    = 1'b1;
      cleared.member_bool_value = 1'b1;
      cleared.urgency_held      = cfg.urgency_default;
   end

   always_comb begin
      stepped = state_cur;
      if (!state_cur.error_seen) begin
         case (state_cur.phase)
            pfp_pkg::PH_START, pfp_pkg::PH_AFTER_COMMA: begin
               if (c != CH_SPACE) begin
                  if (!key_first) begin
                     stepped.error_seen = 1'b1;
                  end else begin
                     stepped.key_kind = (c == CH_LOW_U) ? pfp_pkg::KIND_U :
                                        (c == CH_LOW_I) ? pfp_pkg::KIND_I :
                                        pfp_pkg::KIND_OTHER;
                     stepped.value_negative    = 1'b0;
                     stepped.digits_seen       = 1'b0;
                     stepped.all_digits        = 1'b1;
                     stepped.number_accum      = '0;
                     stepped.member_is_bool    = 1'b1;
                     stepped.member_bool_value = 1'b1;
                     stepped.phase             = pfp_pkg::PH_KEY;
                  end
               end
            end
            pfp_pkg::PH_KEY: begin
               if (key_tail) begin
                  stepped.key_kind = pfp_pkg::KIND_OTHER;
               end else if (c == CH_EQUAL) begin
                  stepped.member_is_bool    = 1'b0;
                  stepped.member_bool_value = 1'b0;
                  stepped.phase             = pfp_pkg::PH_VALUE_FIRST;
               end else if (c == CH_COMMA) begin
                  stepped       = apply_member(state_cur, cfg.urgency_limit);
                  stepped.phase = pfp_pkg::PH_AFTER_COMMA;
               end else if (!visible) begin
                  stepped.error_seen = 1'b1;
               end else begin
                  stepped.phase = pfp_pkg::PH_PARAMS;
               end
            end
            pfp_pkg::PH_VALUE_FIRST: begin
               if (c == CH_QUEST) begin
                  stepped.phase = pfp_pkg::PH_BOOL_DIGIT;
               end else if (c == CH_QUOTE) begin
                  stepped.phase = pfp_pkg::PH_STRING;
               end else if ((c == CH_COMMA) || (c == CH_SEMI) || (c == CH_SPACE)
                            || !visible) begin
                  stepped.error_seen = 1'b1;
               end else begin
                  if (c == CH_MINUS) begin
                     stepped.value_negative = 1'b1;
                  end else if (digit) begin
                     stepped.digits_seen = 1'b1;
                     if (state_cur.all_digits) begin
                        stepped.number_accum = (accum_sum > AccumMax) ?
                           AccumMax[pfp_pkg::AccumWidth-1:0] :
                           accum_sum[pfp_pkg::AccumWidth-1:0];
                     end
                  end else begin
                     stepped.all_digits = 1'b0;
                  end
                  stepped.phase = pfp_pkg::PH_BARE;
               end
            end
            pfp_pkg::PH_BOOL_DIGIT: begin
               if ((c == CH_ZERO) || (c == CH_ONE)) begin
                  stepped.member_is_bool    = 1'b1;
                  stepped.member_bool_value = (c == CH_ONE);
                  stepped.phase             = pfp_pkg::PH_PARAMS;
               end else begin
                  stepped.error_seen = 1'b1;
               end
            end
            pfp_pkg::PH_STRING: begin
               if (c == CH_QUOTE) begin
                  stepped.phase = pfp_pkg::PH_PARAMS;
               end else if (c == CH_BSLASH) begin
                  stepped.phase = pfp_pkg::PH_STRING_ESC;
               end else if (!visible) begin
                  stepped.error_seen = 1'b1;
               end
            end
            pfp_pkg::PH_STRING_ESC: begin
               if (visible) begin
                  stepped.phase = pfp_pkg::PH_STRING;
               end else begin
                  stepped.error_seen = 1'b1;
               end
            end
            pfp_pkg::PH_BARE: begin
               if ((c == CH_SEMI) || (c == CH_SPACE)) begin
                  stepped.phase = pfp_pkg::PH_PARAMS;
               end else if (c == CH_COMMA) begin
                  stepped       = apply_member(state_cur, cfg.urgency_limit);
                  stepped.phase = pfp_pkg::PH_AFTER_COMMA;
               end else if (!visible) begin
                  stepped.error_seen = 1'b1;
               end else if (digit) begin
                  stepped.digits_seen = 1'b1;
                  if (state_cur.all_digits) begin
                     stepped.number_accum = (accum_sum > AccumMax) ?
                        AccumMax[pfp_pkg::AccumWidth-1:0] :
                        accum_sum[pfp_pkg::AccumWidth-1:0];
                  end
               end else begin
                  stepped.all_digits = 1'b0;
               end
            end
            pfp_pkg::PH_PARAMS: begin
               if (c == CH_COMMA) begin
                  stepped       = apply_member(state_cur, cfg.urgency_limit);
                  stepped.phase = pfp_pkg::PH_AFTER_COMMA;
               end else if (!visible) begin
                  stepped.error_seen = 1'b1;
               end else begin
                  stepped.phase = pfp_pkg::PH_PARAMS;
               end
            end
            default: begin
               stepped.error_seen = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      finished = stepped;
      if (!stepped.error_seen) begin
         case (stepped.phase)
            pfp_pkg::PH_START: begin
               finished = stepped;
            end
            pfp_pkg::PH_KEY, pfp_pkg::PH_BARE, pfp_pkg::PH_PARAMS: begin
               finished = apply_member(stepped, cfg.urgency_limit);
            end
            default: begin
               finished.error_seen = 1'b1;
            end
         endcase
      end
      if (item.empty_value) begin
         finished = cleared;
      end
   end

   assign ok = !finished.error_seen;

   always_comb begin
      result.accepted            = ok;
      result.urgency             = (ok && finished.urgency_found) ?
                                   finished.urgency_held : cfg.urgency_default;
      result.incremental         = ok && finished.incremental_found
                                   && finished.incremental_held;
      result.urgency_present     = ok && finished.urgency_found;
      result.incremental_present = ok && finished.incremental_found;
   end

   assign result_valid = item.last_byte || item.empty_value;
   assign state_next   = result_valid ? cleared : stepped;

endmodule
`default_nettype wire

// ----- rtl/priority_field_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Ports                                   Moves
// request   in         req_valid, req_stall, req_data          one value octet per item
// response  out        rsp_valid, rsp_stall, rsp_data          one parse result per item
// csr       in         csr_write_enable, csr_index, csr_write_data  register write
//
// Each octet is taken when not stalled; its result, on the last octet or an empty value,
// is registered and appears the cycle after.
// Reset is synchronous and returns the parser to the start of a value with the
// registers at their default values.
// A request that produces no result is taken even while a response waits; one that
// produces a result is held off only while the waiting response is stalled.
module priority_field_parser (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire pfp_pkg::pfp_req_type                req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output pfp_pkg::pfp_rsp_type                     rsp_data,
   input  wire logic                                csr_write_enable,
   input  wire logic [pfp_pkg::IndexWidth-1:0]      csr_index,
   input  wire logic [pfp_pkg::CsrDataWidth-1:0]    csr_write_data
);

   pfp_pkg::pfp_cfg_type     cfg_ff;
   pfp_pkg::pfp_cfg_type     cfg_in;
   pfp_pkg::parse_state_type state_ff;
   pfp_pkg::parse_state_type state_in;
   pfp_pkg::parse_state_type state_step;
   pfp_pkg::parse_state_type state_reset;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   pfp_pkg::pfp_rsp_type     rsp_data_ff;
   pfp_pkg::pfp_rsp_type     rsp_data_in;
   pfp_pkg::pfp_rsp_type     step_result;
   logic                     step_result_valid;
   logic                     req_take;

   pfp_step u_step (
      .state_cur    (state_ff),
      .item         (req_data),
      .cfg          (cfg_ff),
      .state_next   (state_step),
      .result_valid (step_result_valid),
      .result       (step_result)
   );

   assign req_stall = rsp_valid_ff && rsp_stall && step_result_valid;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            pfp_pkg::CSR_URGENCY_DEFAULT: cfg_in.urgency_default = csr_write_data;
            pfp_pkg::CSR_URGENCY_LIMIT:   cfg_in.urgency_limit   = csr_write_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_reset                   = '0;
      state_reset.phase             = pfp_pkg::PH_START;
      state_reset.key_kind          = pfp_pkg::KIND_NONE;
      state_reset.all_digits        = 1'b1;
      state_reset.member_is_bool    = 1'b1;
      state_reset.member_bool_value = 1'b1;
      state_reset.urgency_held      = pfp_pkg::URGENCY_DEFAULT_RESET;
   end

   always_comb begin
      state_in     = req_take ? state_step : state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (req_take && step_result_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= {pfp_pkg::URGENCY_DEFAULT_RESET, pfp_pkg::URGENCY_LIMIT_RESET};
         state_ff     <= state_reset;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
